[hdl/pstuq_pkg.sv]
// Shared types, constants and helpers for the prefix-sum tree block.
// Used by pstuq_core and prefix_sum_tree_update_query; no dependencies.
package pstuq_pkg;

  localparam int IDX_W        = 10;
  localparam int NODE_W       = 64;
  localparam int DELTA_W      = 32;
  localparam int TREE_DEPTH   = 1 << IDX_W;
  localparam logic [IDX_W-1:0] MAX_ENTRIES = IDX_W'(1023);
  localparam logic [IDX_W-1:0] SIZE_RESET  = IDX_W'(1023);

  // request kinds carried on in_tuser
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [NODE_W-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    logic              kind;
    logic [IDX_W-1:0]  position;
    logic [DELTA_W-1:0] delta;
    logic [IDX_W-1:0]  range_start;
    logic [IDX_W-1:0]  range_end;
  } req_t;

  // lowest set bit, one bit wider than an index so k + lowbit(k) can pass the top
  function automatic logic [IDX_W:0] low_bit(input logic [IDX_W:0] v);
    low_bit = v & (~v + (IDX_W+1)'(1));
  endfunction

endpackage

[hdl/pstuq_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module pstuq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/pstuq_core.sv]
// Tree walk sequencer: clearing pass, add walk (read-modify-write per node),
// two-walk range query with accumulator, and the result register.
// Depends on pstuq_pkg; drives the node RAM through a mem_req_t.
module pstuq_core
  import pstuq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  size,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output mem_req_t          mem_req,
  input  logic [NODE_W-1:0] mem_rd_data,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [NODE_W-1:0] res_total,
  output logic              res_bad
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_Q_HI, ST_Q_LO, ST_Q_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W:0]    k_r, k_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [NODE_W-1:0] delta_r, delta_nxt;
  logic [NODE_W-1:0] acc_r, acc_nxt;
  logic              bad_r, bad_nxt;
  logic              rd_vld_r, rd_sub_r, rd_sub_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_total_r, out_total_nxt;
  logic              out_bad_r, out_bad_nxt;

  logic [IDX_W:0]    low, k_up, k_dn;
  logic              out_free;

  assign low      = low_bit(k_r);
  assign k_up     = k_r + low;
  assign k_dn     = k_r - low;
  assign out_free = !out_valid_r || res_ready;

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = out_valid_r;
  assign res_total = out_total_r;
  assign res_bad   = out_bad_r;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    clr_idx_nxt   = clr_idx_r;
    delta_nxt     = delta_r;
    bad_nxt       = bad_r;
    rd_sub_nxt    = rd_sub_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_total_nxt = out_total_r;
    out_bad_nxt   = out_bad_r;
    mem_req       = '0;

    // read data lands in the cycle after issue
    if (rd_vld_r) begin
      acc_nxt = rd_sub_r ? (acc_r - mem_rd_data) : (acc_r + mem_rd_data);
    end else begin
      acc_nxt = acc_r;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = clr_idx_r;
        mem_req.wr_data = '0;
        clr_idx_nxt     = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == {IDX_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req.kind == REQ_ADD) begin
            if (req.position < size) begin
              k_nxt     = {1'b0, req.position} + (IDX_W+1)'(1);
              delta_nxt = {{(NODE_W-DELTA_W){req.delta[DELTA_W-1]}}, req.delta};
              state_nxt = ST_ADD_RD;
            end
          end else begin
            acc_nxt = '0;
            if (req.range_end >= size || req.range_start > req.range_end) begin
              bad_nxt   = 1'b1;
              state_nxt = ST_Q_FIN;
            end else begin
              bad_nxt   = 1'b0;
              k_nxt     = {1'b0, req.range_end} + (IDX_W+1)'(1);
              lo_nxt    = req.range_start;
              state_nxt = ST_Q_HI;
            end
          end
        end
      end
      ST_ADD_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = k_r[IDX_W-1:0];
        state_nxt       = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        // write node k, fetch the next one up in the same cycle
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = k_r[IDX_W-1:0];
        mem_req.wr_data = mem_rd_data + delta_r;
        if (k_up <= {1'b0, size}) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = k_up[IDX_W-1:0];
          k_nxt           = k_up;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_Q_HI: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = k_r[IDX_W-1:0];
        rd_sub_nxt      = 1'b0;
        k_nxt           = k_dn;
        if (k_dn == '0) begin
          k_nxt     = {1'b0, lo_r};
          state_nxt = ST_Q_LO;
        end
      end
      ST_Q_LO: begin
        if (k_r == '0) begin
          state_nxt = ST_Q_FIN;
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = k_r[IDX_W-1:0];
          rd_sub_nxt      = 1'b1;
          k_nxt           = k_dn;
        end
      end
      ST_Q_FIN: begin
        if (!rd_vld_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = acc_r;
          out_bad_nxt   = bad_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      rd_vld_r    <= mem_req.rd_en;
      out_valid_r <= out_valid_nxt;
    end
    k_r         <= k_nxt;
    lo_r        <= lo_nxt;
    delta_r     <= delta_nxt;
    acc_r       <= acc_nxt;
    bad_r       <= bad_nxt;
    rd_sub_r    <= rd_sub_nxt;
    out_total_r <= out_total_nxt;
    out_bad_r   <= out_bad_nxt;
  end

endmodule

[hdl/prefix_sum_tree_update_query.sv]
// Add: an upward walk over n nodes (at most 10), each read then written; no result beat.
// Query: two downward walks of a and b nodes (each <= 10) into an accumulator;
// out-of-range query: flagged bad without a walk. One item in flight; bounded by the single RAM
// read/write port per node visit. After reset a clearing pass writes all 1024
// nodes to zero (in_tready low); cfg writes are taken meanwhile.
// Top level: size register, beat unpacking, node RAM and walk sequencer.
// Depends on pstuq_pkg, pstuq_ram, pstuq_core.
module prefix_sum_tree_update_query
  import pstuq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,   // used_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // position[9:0], delta[41:10], range_start[51:42],
                                     // range_end[61:52], zero pad[63:62]
  input  logic        in_tuser,      // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,     // range_total[63:0]
  output logic        out_tuser      // bad_range
);

  logic [IDX_W-1:0]  used_size_r;
  logic [IDX_W-1:0]  size;
  req_t              req;
  mem_req_t          mem_req;
  logic [NODE_W-1:0] mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      used_size_r <= cfg_wr_data;
    end
  end

  assign size = (used_size_r > MAX_ENTRIES) ? MAX_ENTRIES : used_size_r;

  assign req.kind        = in_tuser;
  assign req.position    = in_tdata[9:0];
  assign req.delta       = in_tdata[41:10];
  assign req.range_start = in_tdata[51:42];
  assign req.range_end   = in_tdata[61:52];

  pstuq_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TREE_DEPTH)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (mem_req.wr_en),
    .wr_addr (mem_req.wr_addr),
    .wr_data (mem_req.wr_data),
    .rd_en   (mem_req.rd_en),
    .rd_addr (mem_req.rd_addr),
    .rd_data (mem_rd_data)
  );

  pstuq_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .size        (size),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req         (req),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_total   (out_tdata),
    .res_bad     (out_tuser)
  );

endmodule

[test/prefix_sum_tree_update_query_check.sv]
// Checker for the prefix-sum tree: mirrors the node store and used_size from the
// observed config and input beats, predicts each query result and compares it.
// Depends on pstuq_pkg for widths and request codes.
module prefix_sum_tree_update_query_check
  import pstuq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending_n,
  output int          checked_n
);

  typedef struct packed {
    logic [NODE_W-1:0] total;
    logic              bad;
  } range_sum_t;

  logic [NODE_W-1:0] node_mem [0:TREE_DEPTH-1];
  logic [IDX_W-1:0]  size_reg;
  range_sum_t        sum_fifo [$];

  function automatic logic [IDX_W:0] live_size();
    return (size_reg > MAX_ENTRIES) ? {1'b0, MAX_ENTRIES} : {1'b0, size_reg};
  endfunction

  // upward walk: next node adds the lowest set bit
  task automatic tree_add(input logic [IDX_W-1:0] pos, input logic [DELTA_W-1:0] delta);
    logic [IDX_W:0]    k;
    logic [IDX_W:0]    lim;
    logic [NODE_W-1:0] wide;
    lim  = live_size();
    wide = {{(NODE_W-DELTA_W){delta[DELTA_W-1]}}, delta};
    if ({1'b0, pos} >= lim) return;
    k = {1'b0, pos} + (IDX_W+1)'(1);
    while (k <= lim) begin
      node_mem[k[IDX_W-1:0]] = node_mem[k[IDX_W-1:0]] + wide;
      k = k + (k & (~k + (IDX_W+1)'(1)));
    end
  endtask

  // sum of entries 0..count-1, downward walk clearing the lowest set bit
  function automatic logic [NODE_W-1:0] head_sum(input logic [IDX_W:0] count);
    logic [NODE_W-1:0] acc;
    logic [IDX_W:0]    k;
    acc = '0;
    k   = count;
    while (k != 0) begin
      if (k <= {1'b0, MAX_ENTRIES}) acc = acc + node_mem[k[IDX_W-1:0]];
      k = k - (k & (~k + (IDX_W+1)'(1)));
    end
    return acc;
  endfunction

  function automatic range_sum_t range_query(input logic [IDX_W-1:0] lo,
                                             input logic [IDX_W-1:0] hi);
    range_sum_t r;
    if ({1'b0, hi} >= live_size() || lo > hi) begin
      r.total = '0;
      r.bad   = 1'b1;
    end else begin
      r.total = head_sum({1'b0, hi} + (IDX_W+1)'(1)) - head_sum({1'b0, lo});
      r.bad   = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    range_sum_t want;
    if (!rst_n) begin
      foreach (node_mem[i]) node_mem[i] = '0;
      size_reg = SIZE_RESET;
      sum_fifo.delete();
    end else begin
      // result beat first: it always belongs to an older query
      if (out_tvalid && out_tready) begin
        if (sum_fifo.size() == 0) begin
          $error("unexpected result beat: range_total %h bad_range %b", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = sum_fifo.pop_front();
          checked_n++;
          if (out_tdata !== want.total) begin
            $error("range_total: expected %0d, got %0d", $signed(want.total),
                   $signed(out_tdata));
            fail_count++;
          end
          if (out_tuser !== want.bad) begin
            $error("bad_range: expected %b, got %b", want.bad, out_tuser);
            fail_count++;
          end
        end
      end
      // a beat taken on the same edge as a size write still sees the old size
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_ADD) tree_add(in_tdata[9:0], in_tdata[41:10]);
        else sum_fifo = {sum_fifo, range_query(in_tdata[51:42], in_tdata[61:52])};
      end
      if (cfg_wr_en) size_reg = cfg_wr_data;
    end
    pending_n = sum_fifo.size();
  end

endmodule

[test/prefix_sum_tree_update_query_test.sv]
// Testbench top for prefix_sum_tree_update_query: clock, reset, add/query stimulus
// over several used_size settings, random back-pressure and the final verdict.
// Depends on pstuq_pkg, the block and prefix_sum_tree_update_query_check.
module prefix_sum_tree_update_query_test;
  import pstuq_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [9:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;       // position[9:0], delta[41:10], range_start[51:42],
                                    // range_end[61:52], zero pad[63:62]
  logic        in_tuser = 1'b0;     // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;           // range_total[63:0]
  logic        out_tuser;           // bad_range

  int fail_count, pending_n, checked_n;
  int n_adds, n_queries, n_settings;
  int stall_left;
  logic calm = 1'b0;
  logic gappy = 1'b0;

  int phase_size [9] = '{1, 0, 512, 37, 1023, 300, 2, 900, 1023};
  int phase_len  [9] = '{100, 40, 120, 100, 120, 120, 60, 120, 150};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  prefix_sum_tree_update_query uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  prefix_sum_tree_update_query_check sum_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending_n  (pending_n),
    .checked_n  (checked_n)
  );

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = int'($urandom_range(0, 14));
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_size(input logic [9:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    n_settings++;
  endtask

  task automatic send_item(input logic kind, input logic [9:0] pos,
                           input logic [31:0] delta, input logic [9:0] lo,
                           input logic [9:0] hi);
    if (!calm && gappy && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tuser  <= kind;
    in_tdata  <= {2'b00, hi, lo, delta, pos};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == REQ_ADD) n_adds++;
    else n_queries++;
  endtask

  // stop sending, let every query answer, then cover the tail of a trailing add
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_n != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic rand_item(input int size);
    logic        kind;
    logic [9:0]  pos, lo, hi;
    logic [31:0] delta;
    kind = ($urandom_range(0, 99) < 45) ? REQ_ADD : REQ_QUERY;
    pos  = 10'($urandom);
    lo   = 10'($urandom);
    hi   = 10'($urandom);
    case ($urandom_range(0, 7))
      0:       delta = 32'h8000_0000;
      1:       delta = 32'h7fff_ffff;
      2, 3:    delta = $urandom_range(0, 400) - 200;
      default: delta = $urandom;
    endcase
    // mostly in-range work; the rest is whatever the fields allow
    if (size != 0 && $urandom_range(0, 9) != 0) begin
      pos = 10'($urandom_range(0, size - 1));
      lo  = ($urandom_range(0, 5) == 0) ? 10'd0 : 10'($urandom_range(0, size - 1));
      hi  = 10'($urandom_range(lo, size - 1));
    end
    send_item(kind, pos, delta, lo, hi);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_size(10'd1023);

    // directed: extreme deltas and positions, edge ranges, rejected queries
    send_item(REQ_ADD,   10'd0,    32'h7fff_ffff, 10'd0,    10'd0);
    send_item(REQ_ADD,   10'd1022, 32'h8000_0000, 10'd0,    10'd0);
    send_item(REQ_ADD,   10'd1023, 32'h0001_2345, 10'd0,    10'd0);
    send_item(REQ_ADD,   10'd511,  32'hffff_ffff, 10'd0,    10'd0);
    send_item(REQ_ADD,   10'd512,  32'h0000_0001, 10'd0,    10'd0);
    send_item(REQ_ADD,   10'd1,    32'h5555_5555, 10'd0,    10'd0);
    send_item(REQ_ADD,   10'd2,    32'haaaa_aaaa, 10'd0,    10'd0);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd0,    10'd0);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd0,    10'd1022);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd1022, 10'd1022);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd511,  10'd512);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd1,    10'd1021);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd0,    10'd2);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd1,    10'd2);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd0,    10'd1023);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd5,    10'd4);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd1023, 10'd1023);
    send_item(REQ_QUERY, 10'd0,    32'h0,         10'd1023, 10'd0);
    send_item(REQ_ADD,   10'd1023, 32'hffff_ffff, 10'd1023, 10'd1023);
    drain();

    phase_size[5] = int'($urandom_range(2, 1022));
    phase_size[7] = int'($urandom_range(600, 1022));
    for (int p = 0; p < 9; p++) begin
      if (p == 8) calm = 1'b1;
      gappy = ($urandom_range(0, 3) != 0);
      write_size(10'(phase_size[p]));
      for (int i = 0; i < phase_len[p]; i++) rand_item(phase_size[p]);
      drain();
    end
    repeat (16) @(posedge clk);

    $display("covered %0d adds and %0d queries over %0d used_size settings (0 and 1023 incl.)",
             n_adds, n_queries, n_settings);
    $display("compared %0d result beats against the predicted sums", checked_n);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
